### hdl/cha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading package
// Shared widths, fixed-point constants, the stage state type and the
// elaboration-time arctangent table used by the CORDIC vectoring cells.
// ----------------------------------------------------------------------------
package cha_pkg;

  // Width of one axis field on the stream and of the heading field.
  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  // Number of low sample bits taken and sign-extended.
  localparam int SAMPLE_WIDTH  = 16;
  // Number of vectoring cells in the chain.
  localparam int CORDIC_STAGES = 18;

  // Extra fraction bits given to x and y inside the datapath.
  localparam int GUARD_BITS = 16;
  // Datapath width: sample, guard bits, CORDIC gain and sign headroom.
  localparam int XW = SAMPLE_WIDTH + GUARD_BITS + 4;

  // Angle accumulator: signed degrees with DEG_FRAC fraction bits.
  localparam int DEG_FRAC    = 24;
  localparam int OUT_FRAC    = 7;
  localparam int ZW          = DEG_FRAC + 11;
  localparam int ROUND_SHIFT = DEG_FRAC - OUT_FRAC;
  localparam int HW          = ZW - ROUND_SHIFT;

  // Width of the stage index handed to each cell.
  localparam int SHIFT_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  localparam logic [63:0] DEG45_Q24   = 64'd45 << DEG_FRAC;
  localparam logic [63:0] RAD2DEG_Q16 = 64'd3754936;

  localparam logic signed [ZW-1:0] DEG180 = ZW'(64'd180 << DEG_FRAC);
  localparam logic signed [ZW-1:0] DEG360 = ZW'(64'd360 << DEG_FRAC);
  localparam logic [HW-1:0]        FULL_CIRCLE = HW'(360 << OUT_FRAC);
  localparam logic [ZW-1:0]        ROUND_HALF  = ZW'(64'd1 << (ROUND_SHIFT - 1));

  // State carried from one cell to the next.
  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cha_vec_t;

  // atan(2^-idx) in Q24 degrees; entry 0 is exactly 45 degrees.
  // The odd power series is summed in Q60, cut to Q40, then scaled to degrees.
  // Only ever evaluated at elaboration for constant stage numbers.
  function automatic logic [63:0] atan_rom(input int unsigned idx);
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] q40;
    int unsigned k;
    logic        add_term;
    acc      = 64'd0;
    add_term = 1'b1;
    if (idx == 0) begin
      return DEG45_Q24;
    end
    for (k = 1; idx * k < 60; k += 2) begin
      term = (64'd1 << (60 - idx * k)) / 64'(k);
      if (add_term) begin
        acc = acc + term;
      end else begin
        acc = acc - term;
      end
      add_term = !add_term;
    end
    q40 = acc >> 20;
    return (q40 * RAD2DEG_Q16 + (64'd1 << 31)) >> 32;
  endfunction

endpackage

### hdl/cha_prerotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading input cell
// Sign-extends the samples, flags the zero vector and folds vectors with a
// negative x into the right half plane by a 180 degree pre-rotation.
// ----------------------------------------------------------------------------
module cha_prerotate
  import cha_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   y_component,
  input  logic [IN_W-1:0]   x_component,
  output cha_vec_t          out_vec
);

  logic signed [XW-1:0] y_ext;
  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] x_fold;
  logic signed [XW-1:0] y_fold;
  logic signed [ZW-1:0] z_fold;
  logic                 is_zero;

  // Sign extension of the low sample bits.
  assign y_ext = XW'($signed(y_component[SAMPLE_WIDTH-1:0]));
  assign x_ext = XW'($signed(x_component[SAMPLE_WIDTH-1:0]));

  assign is_zero = (x_ext == '0) && (y_ext == '0);

  // Pre-rotation by 180 degrees when x is negative.
  always_comb begin
    if (x_ext < 0) begin
      x_fold = -x_ext;
      y_fold = -y_ext;
      z_fold = DEG180;
    end else begin
      x_fold = x_ext;
      y_fold = y_ext;
      z_fold = '0;
    end
  end

  // Register the folded vector with guard bits appended.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vec.valid <= 1'b0;
    end else if (ce) begin
      out_vec.valid <= in_valid;
    end
    if (ce) begin
      out_vec.zero <= is_zero;
      out_vec.x    <= x_fold <<< GUARD_BITS;
      out_vec.y    <= y_fold <<< GUARD_BITS;
      out_vec.z    <= z_fold;
    end
  end

endmodule

### hdl/cha_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading vectoring cell
// One CORDIC micro-rotation: steers y toward zero and accumulates the
// rotation angle. The stage number and angle are tied to constants.
// ----------------------------------------------------------------------------
module cha_cell
  import cha_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  logic [SHIFT_W-1:0]   stage_idx,
  input  logic signed [ZW-1:0] angle,
  input  cha_vec_t             in_vec,
  output cha_vec_t             out_vec
);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  // Arithmetic shifts round toward minus infinity.
  assign dx = in_vec.y >>> stage_idx;
  assign dy = in_vec.x >>> stage_idx;

  // Rotate against the sign of y.
  always_comb begin
    if (!in_vec.y[XW-1]) begin
      x_next = in_vec.x + dx;
      y_next = in_vec.y - dy;
      z_next = in_vec.z + angle;
    end else begin
      x_next = in_vec.x - dx;
      y_next = in_vec.y + dy;
      z_next = in_vec.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vec.valid <= 1'b0;
    end else if (ce) begin
      out_vec.valid <= in_vec.valid;
    end
    if (ce) begin
      out_vec.zero <= in_vec.zero;
      out_vec.x    <= x_next;
      out_vec.y    <= y_next;
      out_vec.z    <= z_next;
    end
  end

endmodule

### hdl/cha_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading output cell
// Folds negative angles by a full turn, rounds to 1/128 degree, wraps a
// full circle to zero and holds the result for the downstream transfer.
// ----------------------------------------------------------------------------
module cha_finish
  import cha_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  cha_vec_t         in_vec,
  output logic             out_valid,
  output logic [OUT_W-1:0] heading
);

  logic signed [ZW-1:0] z_pos;
  logic [ZW-1:0]        z_round;
  logic [HW-1:0]        h_raw;
  logic [HW-1:0]        h_wrap;
  logic [OUT_W-1:0]     heading_next;

  // Fold into 0 to 360 degrees and round half up.
  assign z_pos   = in_vec.z[ZW-1] ? (in_vec.z + DEG360) : in_vec.z;
  assign z_round = $unsigned(z_pos) + ROUND_HALF;
  assign h_raw   = z_round[ZW-1:ROUND_SHIFT];
  assign h_wrap  = (h_raw >= FULL_CIRCLE) ? (h_raw - FULL_CIRCLE) : h_raw;

  // The zero vector reads as a heading of zero.
  assign heading_next = in_vec.zero ? '0 : OUT_W'(h_wrap);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_vec.valid;
    end
    if (ce) begin
      heading <= heading_next;
    end
  end

endmodule

### hdl/compass_heading_atan2_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading unit
// Four-quadrant arctangent of two magnetometer axis samples, in degrees.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transfer carries a y and an x axis sample, both
//   signed two's complement. Output stream (m_*): one transfer carries the
//   heading in units of 1/128 degree, from 0 to 46079 (0 to under 360).
//   Every input transfer yields exactly one output transfer, in order.
//   The datapath is a row of cells: an input cell for the half-plane fold,
//   18 vectoring cells and an output cell for rounding, each with its own
//   register; the output cell holds the output register. A new pair
//   is accepted in every cycle while the output side keeps up.
//   The zero vector gives a heading of 0; a rounded full circle wraps to 0.
//   When the receiver holds m_tready low with a result waiting, the whole
//   row of cells freezes and s_tready falls; nothing is lost or repeated.
//   Reset clears the valid flag of every cell; items in flight are dropped.
//   Nothing is kept from one item to the next.
// ----------------------------------------------------------------------------
module compass_heading_atan2_unit
  import cha_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [2*IN_W-1:0]    s_tdata,   // [15:0] y_component, [31:16] x_component
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata    // [15:0] heading
);

  cha_vec_t stage_vec [0:CORDIC_STAGES];
  logic     ce;

  // The row advances whenever the output register is free or being drained.
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // Input cell.
  cha_prerotate u_prerotate (
    .clk         (clk),
    .rst         (rst),
    .ce          (ce),
    .in_valid    (s_tvalid),
    .y_component (s_tdata[IN_W-1:0]),
    .x_component (s_tdata[2*IN_W-1:IN_W]),
    .out_vec     (stage_vec[0])
  );

  // Chain of vectoring cells.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    localparam logic signed [ZW-1:0] ANGLE = signed'(ZW'(atan_rom(g)));
    localparam logic [SHIFT_W-1:0]   IDX   = SHIFT_W'(g);

    cha_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .stage_idx (IDX),
      .angle     (ANGLE),
      .in_vec    (stage_vec[g]),
      .out_vec   (stage_vec[g+1])
    );
  end

  // Output cell.
  cha_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_vec    (stage_vec[CORDIC_STAGES]),
    .out_valid (m_tvalid),
    .heading   (m_tdata)
  );

endmodule

### sim/heading_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading checker
// Watches both stream channels of the heading unit. For every input transfer
// it computes the expected heading with its own CORDIC vectoring model. Each
// output transfer is compared with the oldest pending heading. Mismatches and
// results that arrive with nothing expected are counted for the top level.
// ----------------------------------------------------------------------------
module heading_checker
  import cha_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [2*IN_W-1:0] s_tdata,   // [15:0] y_component, [31:16] x_component
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [OUT_W-1:0]  m_tdata,   // [15:0] heading
  output int                mismatches,
  output int                pending,
  output int                checked
);

  localparam int     MAX_REPORTS  = 10;
  localparam int     FRAC_GUARD   = 16;
  localparam int     ANGLE_FRAC   = 24;
  localparam int     HEADING_FRAC = 7;
  localparam longint HALF_TURN    = longint'(180) <<< ANGLE_FRAC;
  localparam longint FULL_TURN    = longint'(360) <<< ANGLE_FRAC;
  localparam longint FULL_HEADING = 46080;

  // One pending heading, with the axis pair that caused it for reporting.
  typedef struct {
    logic [IN_W-1:0]  y_axis;
    logic [IN_W-1:0]  x_axis;
    logic [OUT_W-1:0] heading;
  } heading_entry_t;

  heading_entry_t heading_q[$];
  longint         micro_angle[CORDIC_STAGES];

  // Angle of one micro-rotation, atan(2^-n), in degrees with 24 fraction bits.
  // The arctangent series is summed in radians with 60 fraction bits, cut to
  // 40 fraction bits and scaled by 180/pi held with 16 fraction bits.
  function automatic longint micro_angle_deg(input int n);
    bit [63:0] series;
    bit [63:0] radians_q40;
    bit        negative_term;
    int        power;
    series        = 64'd0;
    negative_term = 1'b0;
    if (n == 0) begin
      return longint'(45) <<< ANGLE_FRAC;
    end
    for (power = 1; n * power < 60; power += 2) begin
      if (negative_term) begin
        series -= (64'd1 << (60 - n * power)) / 64'(power);
      end else begin
        series += (64'd1 << (60 - n * power)) / 64'(power);
      end
      negative_term = !negative_term;
    end
    radians_q40 = series >> 20;
    return longint'((radians_q40 * 64'd3754936 + (64'd1 << 31)) >> 32);
  endfunction

  // Heading in 1/128 degree of the vector (x, y), folded into 0 to 360.
  function automatic logic [OUT_W-1:0] heading_of(input logic [IN_W-1:0] y_raw,
                                                  input logic [IN_W-1:0] x_raw);
    longint xv;
    longint yv;
    longint zv;
    longint step_x;
    longint step_y;
    longint rounded;
    int     n;
    xv = longint'(signed'(y_raw[SAMPLE_WIDTH-1:0]));
    yv = xv;
    xv = longint'(signed'(x_raw[SAMPLE_WIDTH-1:0]));
    zv = 0;
    if (xv == 0 && yv == 0) begin
      return '0;
    end
    // Vectors in the left half plane are turned through half a circle.
    if (xv < 0) begin
      xv = -xv;
      yv = -yv;
      zv = HALF_TURN;
    end
    xv = xv <<< FRAC_GUARD;
    yv = yv <<< FRAC_GUARD;
    // Each stage rotates towards the x axis and books the angle it turned.
    for (n = 0; n < CORDIC_STAGES; n++) begin
      step_x = yv >>> n;
      step_y = xv >>> n;
      if (yv >= 0) begin
        xv += step_x;
        yv -= step_y;
        zv += micro_angle[n];
      end else begin
        xv -= step_x;
        yv += step_y;
        zv -= micro_angle[n];
      end
    end
    if (zv < 0) begin
      zv += FULL_TURN;
    end
    rounded = (zv + (longint'(1) <<< (ANGLE_FRAC - HEADING_FRAC - 1)))
              >>> (ANGLE_FRAC - HEADING_FRAC);
    if (rounded >= FULL_HEADING) begin
      rounded -= FULL_HEADING;
    end
    return OUT_W'(rounded);
  endfunction

  initial begin
    for (int n = 0; n < CORDIC_STAGES; n++) begin
      micro_angle[n] = micro_angle_deg(n);
    end
  end

  // Compare completed results first, then book the new expectation.
  always @(posedge clk) begin
    heading_entry_t oldest;
    heading_entry_t fresh;
    if (rst) begin
      heading_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (heading_q.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("%0t: heading %0d transferred with no result pending",
                     $realtime, m_tdata);
          end
          mismatches <= mismatches + 1;
        end else begin
          oldest = heading_q.pop_front();
          if (m_tdata !== oldest.heading) begin
            if (mismatches < MAX_REPORTS) begin
              $display("%0t: heading mismatch for y=%0d x=%0d: expected %0d, got %0d",
                       $realtime, signed'(oldest.y_axis), signed'(oldest.x_axis),
                       oldest.heading, m_tdata);
            end
            mismatches <= mismatches + 1;
          end
          checked <= checked + 1;
        end
      end
      if (s_tvalid && s_tready) begin
        fresh.y_axis  = s_tdata[IN_W-1:0];
        fresh.x_axis  = s_tdata[2*IN_W-1:IN_W];
        fresh.heading = heading_of(fresh.y_axis, fresh.x_axis);
        heading_q.push_back(fresh);
      end
    end
    pending <= heading_q.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading unit testbench
// Sends axis pairs to the heading unit: first directed edge cases (zero
// vector, axis directions, extreme samples, the wrap at a full circle), then
// random pairs under four idle patterns, with one long output hold that fills
// the pipeline. A separate checker predicts and compares every heading.
// ----------------------------------------------------------------------------
module testbench
  import cha_pkg::*;
();

  localparam int PHASE_ITEMS = 382;
  localparam int LONG_HOLD   = 200;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 40;

  typedef enum int {AXIS_ANY, AXIS_TINY, AXIS_CORNER, AXIS_WIDE} axis_class_e;

  localparam logic [IN_W-1:0] CORNERS [6] = '{16'h7FFF, 16'h8000, 16'h8001,
                                              16'hFFFF, 16'h0000, 16'h0001};

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [2*IN_W-1:0] s_tdata;   // [15:0] y_component, [31:16] x_component
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;   // [15:0] heading

  int mismatches;
  int pending;
  int checked;
  int sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int quiet_cycles;

  compass_heading_atan2_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  heading_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random stalls, or a long hold counted down here.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready    <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Offers one pair, possibly after idle cycles, and waits for its transfer.
  // Called and returning at a falling edge.
  task automatic send_pair(input logic [IN_W-1:0] y_axis, input logic [IN_W-1:0] x_axis);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {x_axis, y_axis};
    do begin
      @(posedge clk);
    end while (!s_tready);
    sent = sent + 1;
    @(negedge clk);
  endtask

  // One random axis sample, biased towards small, extreme and large values.
  function automatic logic [IN_W-1:0] random_axis();
    axis_class_e pick;
    pick = axis_class_e'($urandom_range(3));
    case (pick)
      AXIS_TINY: begin
        return IN_W'(int'($urandom_range(32)) - 16);
      end
      AXIS_CORNER: begin
        return CORNERS[$urandom_range(5)];
      end
      AXIS_WIDE: begin
        if ($urandom_range(1) == 1) begin
          return IN_W'($urandom_range(32767, 16384));
        end else begin
          return IN_W'(-int'($urandom_range(32768, 16384)));
        end
      end
      default: begin
        return IN_W'($urandom);
      end
    endcase
  endfunction

  task automatic random_phase(input int idle_pct, input int stall_pct, input bit with_hold);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // Part way in, hold the output off while pairs keep coming.
      if (with_hold && n == 40) begin
        hold_cycles = LONG_HOLD;
      end
      send_pair(random_axis(), random_axis());
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    sent           = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pairs, given as (y, x): zero vector, axes, extremes, diagonals
    // and a vector just below the x axis that rounds to a full circle.
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd1);
    send_pair(16'sd0, -16'sd1);
    send_pair(16'sd1, 16'sd0);
    send_pair(-16'sd1, 16'sd0);
    send_pair(16'sd0, 16'sd32767);
    send_pair(16'sd0, 16'h8000);
    send_pair(16'sd32767, 16'sd0);
    send_pair(16'h8000, 16'sd0);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'sd32767, 16'h8000);
    send_pair(16'h8000, 16'sd32767);
    send_pair(16'sd1, 16'sd1);
    send_pair(-16'sd1, -16'sd1);
    send_pair(16'sd1, -16'sd1);
    send_pair(-16'sd1, 16'sd1);
    send_pair(-16'sd1, 16'sd32767);
    send_pair(-16'sd1, 16'h8000);
    send_pair(16'sd1, 16'h8000);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'hAAAA, 16'h5555);
    send_pair(16'h8000, -16'sd1);
    send_pair(16'sd32767, 16'sd1);

    // Random pairs under each idle pattern; the first includes the long hold.
    random_phase(0, 0, 1'b1);
    random_phase(84, 0, 1'b0);
    random_phase(0, 84, 1'b0);
    random_phase(6, 6, 1'b0);
    s_tvalid <= 1'b0;

    // Drain, then allow for any stray result to appear.
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d axis pairs and checked %0d headings: directed edge cases,",
             sent, checked);
    $display("then random pairs under four idle patterns and a %0d-cycle output hold.",
             LONG_HOLD);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d heading errors", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
